>>> sv/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// shared types and constants of the vertex normal accumulator
// ----------------------------------------------------------------------------
package vna_pkg;

   localparam int IDX_W   = 10;   // vertex slot index width
   localparam int COORD_W = 16;   // q8.8 coordinate
   localparam int EDGE_W  = 17;   // coordinate difference
   localparam int PROD_W  = 34;   // edge by edge product
   localparam int CROSS_W = 35;   // cross product component
   localparam int NORM_W  = 16;   // q1.15 normal component
   localparam int VTX_W   = 3 * COORD_W;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TRI  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VTX_A,
      ST_VTX_B,
      ST_VTX_C,
      ST_VTX_D,
      ST_CROSS,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_RD_MEM,
      ST_RD_START,
      ST_RD_NORM,
      ST_RD_OUT
   } core_state_type;

   typedef enum logic [2:0] {
      NS_IDLE,
      NS_MAX,
      NS_SHIFT,
      NS_SQUARE,
      NS_ROOT,
      NS_DIV_INIT,
      NS_DIV_STEP,
      NS_DONE
   } norm_state_type;

   typedef struct packed {
      logic                     degenerate;
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
      logic signed [NORM_W-1:0] z;
   } norm_result_type;

endpackage

>>> sv/vertex_normal_accumulator_core.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_core
// area-weighted smooth vertex normals over a vertex store and accumulator memory
// ----------------------------------------------------------------------------
// load: one write of the vertex and of its zeroed accumulator slot. triangle: 3 vertex
//   reads, 7 multiply steps on one shared 17x17 multiplier, 3 read-modify-writes of the accumulator memory.
// read: for a non-zero accumulator, the normalising shift (one bit a cycle), a
//   32-step square root and three 18-step divisions in vna_norm; a zero vector skips
//   them, and a slot out of range skips vna_norm and returns a degenerate result.
// one transaction at a time; a finished result waits in the output register.
// after reset the accumulator memory is swept to zero, one entry a cycle over all
//   min(MAX_VERTICES, 1024) entries, with req_stall held high.
module vertex_normal_accumulator_core #(
   parameter int MAX_VERTICES = 1024,
   parameter int ACCUM_BITS   = 40
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_opcode,
   input  logic [vna_pkg::IDX_W-1:0]             req_vertex_index,
   input  logic signed [vna_pkg::COORD_W-1:0]    req_pos_x,
   input  logic signed [vna_pkg::COORD_W-1:0]    req_pos_y,
   input  logic signed [vna_pkg::COORD_W-1:0]    req_pos_z,
   input  logic [vna_pkg::IDX_W-1:0]             req_corner_a,
   input  logic [vna_pkg::IDX_W-1:0]             req_corner_b,
   input  logic [vna_pkg::IDX_W-1:0]             req_corner_c,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vna_pkg::NORM_W-1:0]     rsp_normal_x,
   output logic signed [vna_pkg::NORM_W-1:0]     rsp_normal_y,
   output logic signed [vna_pkg::NORM_W-1:0]     rsp_normal_z,
   output logic [vna_pkg::IDX_W-1:0]             rsp_normal_slot,
   output logic                                  rsp_degenerate
);

   // slots beyond what the index port can reach are never stored
   localparam int DEPTH = (MAX_VERTICES < (1 << vna_pkg::IDX_W)) ?
                          MAX_VERTICES : (1 << vna_pkg::IDX_W);
   localparam int AW    = $clog2(DEPTH);
   localparam int A     = ACCUM_BITS;
   localparam int CW    = vna_pkg::CROSS_W;
   localparam int EW    = vna_pkg::EDGE_W;
   localparam int PW    = vna_pkg::PROD_W;
   localparam int DW    = vna_pkg::COORD_W;

   // control and captured transaction
   vna_pkg::core_state_type state_ff, state_in;
   logic [AW-1:0]                  clr_ff, clr_in;
   logic [2:0]                     cnt_ff, cnt_in;
   logic [vna_pkg::IDX_W-1:0]      corner_a_ff, corner_a_in;
   logic [vna_pkg::IDX_W-1:0]      corner_b_ff, corner_b_in;
   logic [vna_pkg::IDX_W-1:0]      corner_c_ff, corner_c_in;
   logic [vna_pkg::IDX_W-1:0]      slot_ff, slot_in;

   // geometry datapath
   logic [vna_pkg::VTX_W-1:0]      va_ff, va_in;
   logic [vna_pkg::VTX_W-1:0]      vb_ff, vb_in;
   logic signed [EW-1:0]           e1_ff [3];
   logic signed [EW-1:0]           e1_in [3];
   logic signed [EW-1:0]           e2_ff [3];
   logic signed [EW-1:0]           e2_in [3];
   logic signed [PW-1:0]           prod_ff, prod_in;
   logic signed [CW-1:0]           cross_ff [3];
   logic signed [CW-1:0]           cross_in [3];
   logic signed [EW-1:0]           mul_a, mul_b;
   logic signed [CW-1:0]           prod_ext;

   // result holding
   vna_pkg::norm_result_type       res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   vna_pkg::norm_result_type       rsp_res_ff, rsp_res_in;
   logic [vna_pkg::IDX_W-1:0]      rsp_slot_ff, rsp_slot_in;

   // memories
   logic                           vmem_we;
   logic [AW-1:0]                  vmem_waddr, vmem_raddr;
   logic [vna_pkg::VTX_W-1:0]      vmem_wdata, vmem_rdata;
   logic                           amem_we;
   logic [AW-1:0]                  amem_waddr, amem_raddr;
   logic [3*A-1:0]                 amem_wdata, amem_rdata;

   // saturating accumulate, one lane per axis
   logic signed [A-1:0]            acc_old [3];
   logic signed [A:0]              acc_sum [3];
   logic signed [A-1:0]            acc_new [3];

   logic                           accept;
   logic [vna_pkg::IDX_W-1:0]      cur_corner;
   logic                           norm_start;
   logic                           norm_done;
   vna_pkg::norm_result_type       norm_result;

   function automatic logic in_range(input logic [vna_pkg::IDX_W-1:0] idx);
      return (32'(idx) < 32'(MAX_VERTICES));
   endfunction

   function automatic logic signed [EW-1:0] diff(input logic [DW-1:0] p,
                                                 input logic [DW-1:0] q);
      return $signed({p[DW-1], p}) - $signed({q[DW-1], q});
   endfunction

   vna_ram #(
      .WIDTH (vna_pkg::VTX_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (vmem_we),
      .wr_addr (vmem_waddr),
      .wr_data (vmem_wdata),
      .rd_addr (vmem_raddr),
      .rd_data (vmem_rdata)
   );

   vna_ram #(
      .WIDTH (3 * A),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_accum_ram (
      .clock   (clock),
      .wr_en   (amem_we),
      .wr_addr (amem_waddr),
      .wr_data (amem_wdata),
      .rd_addr (amem_raddr),
      .rd_data (amem_rdata)
   );

   vna_norm #(
      .ACCUM_BITS (A)
   ) u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .acc_x  (acc_old[0]),
      .acc_y  (acc_old[1]),
      .acc_z  (acc_old[2]),
      .done   (norm_done),
      .result (norm_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vna_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      corner_a_ff <= corner_a_in;
      corner_b_ff <= corner_b_in;
      corner_c_ff <= corner_c_in;
      slot_ff     <= slot_in;
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      prod_ff     <= prod_in;
      cross_ff    <= cross_in;
      res_ff      <= res_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   // accept only when idle; the output register frees the request side
   assign req_stall = (state_ff != vna_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // corner being worked on during the read-modify-write passes
   always_comb begin
      unique case (cnt_ff)
         3'd0:    cur_corner = corner_a_ff;
         3'd1:    cur_corner = corner_b_ff;
         default: cur_corner = corner_c_ff;
      endcase
   end

   // memory read addresses
   always_comb begin
      unique case (state_ff)
         vna_pkg::ST_VTX_A: vmem_raddr = corner_a_ff[AW-1:0];
         vna_pkg::ST_VTX_B: vmem_raddr = corner_b_ff[AW-1:0];
         default:           vmem_raddr = corner_c_ff[AW-1:0];
      endcase
      amem_raddr = (state_ff == vna_pkg::ST_RD_MEM) ? slot_ff[AW-1:0]
                                                    : cur_corner[AW-1:0];
   end

   // saturate each axis at the accumulator limits
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc_old[k] = $signed(amem_rdata[k*A +: A]);
         acc_sum[k] = $signed({acc_old[k][A-1], acc_old[k]})
                    + $signed({{(A+1-CW){cross_ff[k][CW-1]}}, cross_ff[k]});
         if (acc_sum[k][A] != acc_sum[k][A-1]) begin
            acc_new[k] = acc_sum[k][A] ? $signed({1'b1, {(A-1){1'b0}}})
                                       : $signed({1'b0, {(A-1){1'b1}}});
         end else begin
            acc_new[k] = acc_sum[k][A-1:0];
         end
      end
   end

   // multiplier operand schedule for the cross product
   always_comb begin
      unique case (cnt_ff)
         3'd0:    begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         3'd1:    begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         3'd2:    begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         3'd3:    begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         3'd4:    begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         3'd5:    begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
         default: begin mul_a = '0;       mul_b = '0;       end
      endcase
      prod_ext = $signed({prod_ff[PW-1], prod_ff});
   end

   // main sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      corner_a_in  = corner_a_ff;
      corner_b_in  = corner_b_ff;
      corner_c_in  = corner_c_ff;
      slot_in      = slot_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      prod_in      = prod_ff;
      cross_in     = cross_ff;
      res_in       = res_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      norm_start   = 1'b0;

      vmem_we      = 1'b0;
      vmem_waddr   = req_vertex_index[AW-1:0];
      vmem_wdata   = {req_pos_z, req_pos_y, req_pos_x};
      amem_we      = 1'b0;
      amem_waddr   = cur_corner[AW-1:0];
      amem_wdata   = {acc_new[2], acc_new[1], acc_new[0]};

      unique case (state_ff)
         vna_pkg::ST_CLEAR: begin
            // zero sweep of the accumulator memory after reset
            amem_we    = 1'b1;
            amem_waddr = clr_ff;
            amem_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = vna_pkg::ST_IDLE;
            end
         end
         vna_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  vna_pkg::OP_LOAD: begin
                     if (in_range(req_vertex_index)) begin
                        vmem_we    = 1'b1;
                        amem_we    = 1'b1;
                        amem_waddr = req_vertex_index[AW-1:0];
                        amem_wdata = '0;
                     end
                  end
                  vna_pkg::OP_TRI: begin
                     corner_a_in = req_corner_a;
                     corner_b_in = req_corner_b;
                     corner_c_in = req_corner_c;
                     if (in_range(req_corner_a) && in_range(req_corner_b) &&
                         in_range(req_corner_c)) begin
                        state_in = vna_pkg::ST_VTX_A;
                     end
                  end
                  vna_pkg::OP_READ: begin
                     slot_in = req_vertex_index;
                     if (in_range(req_vertex_index)) begin
                        state_in = vna_pkg::ST_RD_MEM;
                     end else begin
                        res_in   = '{degenerate: 1'b1, x: '0, y: '0, z: '0};
                        state_in = vna_pkg::ST_RD_OUT;
                     end
                  end
                  default: begin
                     // undefined opcode: dropped
                  end
               endcase
            end
         end
         vna_pkg::ST_VTX_A: begin
            state_in = vna_pkg::ST_VTX_B;
         end
         vna_pkg::ST_VTX_B: begin
            va_in    = vmem_rdata;
            state_in = vna_pkg::ST_VTX_C;
         end
         vna_pkg::ST_VTX_C: begin
            vb_in    = vmem_rdata;
            state_in = vna_pkg::ST_VTX_D;
         end
         vna_pkg::ST_VTX_D: begin
            // edges from corner a, third corner straight off the read port
            for (int k = 0; k < 3; k++) begin
               e1_in[k] = diff(vb_ff[k*DW +: DW], va_ff[k*DW +: DW]);
               e2_in[k] = diff(vmem_rdata[k*DW +: DW], va_ff[k*DW +: DW]);
            end
            cnt_in   = '0;
            state_in = vna_pkg::ST_CROSS;
         end
         vna_pkg::ST_CROSS: begin
            // product of step n is folded in at step n+1
            prod_in = mul_a * mul_b;
            unique case (cnt_ff)
               3'd1:    cross_in[0] = prod_ext;
               3'd2:    cross_in[0] = cross_ff[0] - prod_ext;
               3'd3:    cross_in[1] = prod_ext;
               3'd4:    cross_in[1] = cross_ff[1] - prod_ext;
               3'd5:    cross_in[2] = prod_ext;
               3'd6:    cross_in[2] = cross_ff[2] - prod_ext;
               default: begin end
            endcase
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) begin
               cnt_in   = '0;
               state_in = vna_pkg::ST_ACC_RD;
            end
         end
         vna_pkg::ST_ACC_RD: begin
            state_in = vna_pkg::ST_ACC_WR;
         end
         vna_pkg::ST_ACC_WR: begin
            // write lands before the next corner's read, so repeated corners chain
            amem_we = 1'b1;
            if (cnt_ff == 3'd2) begin
               state_in = vna_pkg::ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + 3'd1;
               state_in = vna_pkg::ST_ACC_RD;
            end
         end
         vna_pkg::ST_RD_MEM: begin
            state_in = vna_pkg::ST_RD_START;
         end
         vna_pkg::ST_RD_START: begin
            norm_start = 1'b1;
            state_in   = vna_pkg::ST_RD_NORM;
         end
         vna_pkg::ST_RD_NORM: begin
            if (norm_done) begin
               res_in   = norm_result;
               state_in = vna_pkg::ST_RD_OUT;
            end
         end
         vna_pkg::ST_RD_OUT: begin
            // wait for room in the output register
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_slot_in  = slot_ff;
               state_in     = vna_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vna_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_normal_x    = rsp_res_ff.x;
   assign rsp_normal_y    = rsp_res_ff.y;
   assign rsp_normal_z    = rsp_res_ff.z;
   assign rsp_normal_slot = rsp_slot_ff;
   assign rsp_degenerate  = rsp_res_ff.degenerate;

endmodule

>>> sv/vna_ram.sv
// ----------------------------------------------------------------------------
// vna_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module vna_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/vna_norm.sv
// ----------------------------------------------------------------------------
// vna_norm
// scales an accumulated vector to unit length in q1.15, one step per cycle
// ----------------------------------------------------------------------------
module vna_norm #(
   parameter int ACCUM_BITS = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [ACCUM_BITS-1:0]  acc_x,
   input  logic signed [ACCUM_BITS-1:0]  acc_y,
   input  logic signed [ACCUM_BITS-1:0]  acc_z,
   output logic                          done,
   output vna_pkg::norm_result_type      result
);

   localparam int A = ACCUM_BITS;

   vna_pkg::norm_state_type state_ff, state_in;
   logic [A-1:0]  mag_ff [3];
   logic [A-1:0]  mag_in [3];
   logic          neg_ff [3];
   logic          neg_in [3];
   logic [A-1:0]  mx_ff, mx_in;
   logic [59:0]   sq_ff, sq_in;
   logic [63:0]   sum_ff, sum_in;
   logic [63:0]   res_ff, res_in;
   logic [63:0]   bit_ff, bit_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [1:0]    comp_ff, comp_in;
   logic [30:0]   rem_ff, rem_in;
   logic [16:0]   nlow_ff, nlow_in;
   logic [16:0]   q_ff, q_in;
   logic signed [vna_pkg::NORM_W-1:0] out_ff [3];
   logic signed [vna_pkg::NORM_W-1:0] out_in [3];
   logic          degen_ff, degen_in;

   logic [29:0]   sq_op;
   logic [A-1:0]  max_xy;
   logic [63:0]   trial_root;
   logic [30:0]   root;
   logic [45:0]   num;
   logic [31:0]   trial_div;
   logic [16:0]   q_next;
   logic [15:0]   q_clamp;

   assign root = res_ff[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vna_pkg::NS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      mx_ff    <= mx_in;
      sq_ff    <= sq_in;
      sum_ff   <= sum_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      cnt_ff   <= cnt_in;
      comp_ff  <= comp_in;
      rem_ff   <= rem_in;
      nlow_ff  <= nlow_in;
      q_ff     <= q_in;
      out_ff   <= out_in;
      degen_ff <= degen_in;
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      mx_in    = mx_ff;
      sq_in    = sq_ff;
      sum_in   = sum_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      rem_in   = rem_ff;
      nlow_in  = nlow_ff;
      q_in     = q_ff;
      out_in   = out_ff;
      degen_in = degen_ff;
      done     = 1'b0;

      max_xy     = (mag_ff[1] > mag_ff[0]) ? mag_ff[1] : mag_ff[0];
      trial_root = res_ff + bit_ff;
      num        = {mag_ff[comp_ff][29:0], 15'd0} + 46'(root[30:1]);
      trial_div  = {rem_ff, nlow_ff[16]};
      q_next     = {q_ff[15:0], (trial_div >= {1'b0, root})};
      q_clamp    = (q_next > 17'd32767) ? 16'd32767 : q_next[15:0];

      unique case (cnt_ff[1:0])
         2'd0:    sq_op = mag_ff[0][29:0];
         2'd1:    sq_op = mag_ff[1][29:0];
         2'd2:    sq_op = mag_ff[2][29:0];
         default: sq_op = '0;
      endcase

      unique case (state_ff)
         vna_pkg::NS_IDLE: begin
            if (start) begin
               neg_in[0] = acc_x[A-1];
               neg_in[1] = acc_y[A-1];
               neg_in[2] = acc_z[A-1];
               mag_in[0] = acc_x[A-1] ? (~acc_x + 1'b1) : acc_x;
               mag_in[1] = acc_y[A-1] ? (~acc_y + 1'b1) : acc_y;
               mag_in[2] = acc_z[A-1] ? (~acc_z + 1'b1) : acc_z;
               state_in  = vna_pkg::NS_MAX;
            end
         end
         vna_pkg::NS_MAX: begin
            mx_in = (mag_ff[2] > max_xy) ? mag_ff[2] : max_xy;
            if (mx_in == '0) begin
               degen_in = 1'b1;
               out_in   = '{default: '0};
               state_in = vna_pkg::NS_DONE;
            end else begin
               degen_in = 1'b0;
               state_in = vna_pkg::NS_SHIFT;
            end
         end
         vna_pkg::NS_SHIFT: begin
            // bring the largest magnitude into [2^29, 2^30)
            if (mx_ff[A-1:30] != '0) begin
               mx_in = mx_ff >> 1;
               for (int k = 0; k < 3; k++) mag_in[k] = mag_ff[k] >> 1;
            end else if (!mx_ff[29]) begin
               mx_in = mx_ff << 1;
               for (int k = 0; k < 3; k++) mag_in[k] = mag_ff[k] << 1;
            end else begin
               cnt_in   = '0;
               sum_in   = '0;
               state_in = vna_pkg::NS_SQUARE;
            end
         end
         vna_pkg::NS_SQUARE: begin
            sq_in = sq_op * sq_op;
            if (cnt_ff != 5'd0) begin
               sum_in = sum_ff + 64'(sq_ff);
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               cnt_in   = '0;
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               state_in = vna_pkg::NS_ROOT;
            end
         end
         vna_pkg::NS_ROOT: begin
            // one result bit per cycle
            if (sum_ff >= trial_root) begin
               sum_in = sum_ff - trial_root;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               comp_in  = '0;
               state_in = vna_pkg::NS_DIV_INIT;
            end
         end
         vna_pkg::NS_DIV_INIT: begin
            rem_in   = {2'b00, num[45:17]};
            nlow_in  = num[16:0];
            q_in     = '0;
            cnt_in   = '0;
            state_in = vna_pkg::NS_DIV_STEP;
         end
         vna_pkg::NS_DIV_STEP: begin
            // restoring division, one quotient bit per cycle
            if (trial_div >= {1'b0, root}) begin
               rem_in = 31'(trial_div - {1'b0, root});
            end else begin
               rem_in = trial_div[30:0];
            end
            q_in    = q_next;
            nlow_in = {nlow_ff[15:0], 1'b0};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               out_in[comp_ff] = neg_ff[comp_ff] ? $signed(16'd0 - q_clamp)
                                                 : $signed(q_clamp);
               if (comp_ff == 2'd2) begin
                  state_in = vna_pkg::NS_DONE;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = vna_pkg::NS_DIV_INIT;
               end
            end
         end
         vna_pkg::NS_DONE: begin
            done     = 1'b1;
            state_in = vna_pkg::NS_IDLE;
         end
         default: begin
            state_in = vna_pkg::NS_IDLE;
         end
      endcase
   end

   assign result.degenerate = degen_ff;
   assign result.x          = out_ff[0];
   assign result.y          = out_ff[1];
   assign result.z          = out_ff[2];

endmodule
